// ----- hdl/boundary_phase_winding_counter_top_defines.svh -----
// Assertion macros shared by the winding counter RTL.
`ifndef BOUNDARY_PHASE_WINDING_COUNTER_TOP_DEFINES_SVH
`define BOUNDARY_PHASE_WINDING_COUNTER_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BPWC_ASSERT_NOW(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("winding counter check failed");

// Next-cycle implication, checked outside reset.
`define BPWC_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("winding counter check failed");

`endif

// ----- hdl/bpwc_pkg.sv -----
package bpwc_pkg;

  localparam int MAX_POINTS    = 4096;
  localparam int CORDIC_STEPS  = 16;
  localparam int COUNT_LIMIT   = (MAX_POINTS < 8191) ? MAX_POINTS : 8191;

  localparam int ANGLE_W = 16;
  localparam int COUNT_W = 14;
  localparam int XY_W    = 28;  // 24-bit scaled input plus CORDIC gain and sqrt(2)
  localparam int Z_W     = 26;  // fine angle, 2^-24 turn units
  localparam int ATAN_N  = 24;
  localparam int ATAN_IW = 5;
  localparam int ATAN_W  = 23;

  localparam logic signed [Z_W-1:0] HALF_PI_FINE = 26'sd4194304;
  localparam logic signed [16:0]    ANGLE_THRESHOLD = 17'sd49152;
  localparam logic signed [COUNT_W-1:0] COUNT_LIM = COUNT_W'(COUNT_LIMIT);

  // Micro-ops
  localparam logic [2:0] OP_NOP     = 3'd0;
  localparam logic [2:0] OP_LOAD    = 3'd1;
  localparam logic [2:0] OP_ITER    = 3'd2;
  localparam logic [2:0] OP_ROUND   = 3'd3;
  localparam logic [2:0] OP_ADVANCE = 3'd4;
  localparam logic [2:0] OP_CLOSE   = 3'd5;
  localparam logic [2:0] OP_EMIT    = 3'd6;

  // Jump conditions
  localparam logic [2:0] COND_NEXT      = 3'd0;
  localparam logic [2:0] COND_ALWAYS    = 3'd1;
  localparam logic [2:0] COND_NO_INPUT  = 3'd2;
  localparam logic [2:0] COND_ITER_MORE = 3'd3;
  localparam logic [2:0] COND_NOT_LAST  = 3'd4;
  localparam logic [2:0] COND_OUT_BUSY  = 3'd5;

  // Program addresses
  localparam logic [2:0] STEP_IDLE    = 3'd0;
  localparam logic [2:0] STEP_ITER    = 3'd1;
  localparam logic [2:0] STEP_ROUND   = 3'd2;
  localparam logic [2:0] STEP_ADVANCE = 3'd3;
  localparam logic [2:0] STEP_CLOSE   = 3'd4;
  localparam logic [2:0] STEP_EMIT    = 3'd7;

  typedef struct packed {
    logic [2:0] op;
    logic [2:0] cond;
    logic [2:0] target;
  } bpwc_ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic iter_more;
    logic last;
    logic out_busy;
  } bpwc_flags_t;

  // atan(2^-i) in 2^-24 turn units
  function automatic logic [ATAN_W-1:0] atan_fine(input logic [ATAN_IW-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:  v = 23'd2097152;
      5'd1:  v = 23'd1238021;
      5'd2:  v = 23'd654136;
      5'd3:  v = 23'd332050;
      5'd4:  v = 23'd166669;
      5'd5:  v = 23'd83416;
      5'd6:  v = 23'd41718;
      5'd7:  v = 23'd20860;
      5'd8:  v = 23'd10430;
      5'd9:  v = 23'd5215;
      5'd10: v = 23'd2608;
      5'd11: v = 23'd1304;
      5'd12: v = 23'd652;
      5'd13: v = 23'd326;
      5'd14: v = 23'd163;
      5'd15: v = 23'd81;
      5'd16: v = 23'd41;
      5'd17: v = 23'd20;
      5'd18: v = 23'd10;
      5'd19: v = 23'd5;
      5'd20: v = 23'd3;
      5'd21: v = 23'd1;
      5'd22: v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/bpwc_sequencer.sv -----
module bpwc_sequencer (
  input  logic                  clk,
  input  logic                  rst,
  input  bpwc_pkg::bpwc_flags_t flags,
  output bpwc_pkg::bpwc_ctrl_t  ctrl
);
  import bpwc_pkg::*;

  logic [2:0] pc;
  logic [2:0] pc_next;
  logic       taken;

  // Microprogram: one control word per step
  function automatic bpwc_ctrl_t program_rom(input logic [2:0] addr);
    bpwc_ctrl_t w;
    case (addr)
      STEP_IDLE:    w = '{op: OP_LOAD,    cond: COND_NO_INPUT,  target: STEP_IDLE};
      STEP_ITER:    w = '{op: OP_ITER,    cond: COND_ITER_MORE, target: STEP_ITER};
      STEP_ROUND:   w = '{op: OP_ROUND,   cond: COND_NEXT,      target: STEP_IDLE};
      STEP_ADVANCE: w = '{op: OP_ADVANCE, cond: COND_NOT_LAST,  target: STEP_IDLE};
      STEP_CLOSE:   w = '{op: OP_CLOSE,   cond: COND_ALWAYS,    target: STEP_EMIT};
      STEP_EMIT:    w = '{op: OP_EMIT,    cond: COND_OUT_BUSY,  target: STEP_EMIT};
      default:      w = '{op: OP_NOP,     cond: COND_ALWAYS,    target: STEP_IDLE};
    endcase
    return w;
  endfunction

  assign ctrl = program_rom(pc);

  always_comb begin
    case (ctrl.cond)
      COND_NEXT:      taken = 1'b0;
      COND_ALWAYS:    taken = 1'b1;
      COND_NO_INPUT:  taken = !flags.in_valid;
      COND_ITER_MORE: taken = flags.iter_more;
      COND_NOT_LAST:  taken = !flags.last;
      COND_OUT_BUSY:  taken = flags.out_busy;
      default:        taken = 1'b1;
    endcase
    // fall through wraps from the emit step back to idle
    pc_next = taken ? ctrl.target : pc + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

// ----- hdl/boundary_phase_winding_counter_top.sv -----
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  sample_real, sample_imag, last_point
// output    out        out_valid / out_stall winding_count (last sample only)
//
// Each sample passes through an accept step, CORDIC_STEPS iterations of the
// shared shift-add unit, then round and compare; a last sample adds a close
// step and an emit step.
// Reset (rst, synchronous) clears the microprogram counter, run state and
// output valid. out_stall holds the emit step only while a prior result still
// waits; a new sample is taken while the output register is occupied.
`include "boundary_phase_winding_counter_top_defines.svh"

module boundary_phase_winding_counter_top #(
  parameter int CORDIC_STEPS = bpwc_pkg::CORDIC_STEPS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [15:0]                  sample_real,
  input  logic signed [15:0]                  sample_imag,
  input  logic                                last_point,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [bpwc_pkg::COUNT_W-1:0] winding_count
);
  import bpwc_pkg::*;

  localparam int ITER_W = $clog2(CORDIC_STEPS);

  bpwc_ctrl_t  ctrl;
  bpwc_flags_t flags;

  // CORDIC datapath
  logic signed [XY_W-1:0]    x;
  logic signed [XY_W-1:0]    y;
  logic signed [Z_W-1:0]     z;
  logic [ITER_W-1:0]         iter_cnt;
  logic                      zero_in;
  logic                      last_reg;
  logic signed [ANGLE_W-1:0] angle;

  // Run state
  logic signed [ANGLE_W-1:0] first_angle;
  logic signed [ANGLE_W-1:0] previous_angle;
  logic signed [COUNT_W-1:0] running_count;
  logic                      run_started;

  logic                      in_accept;
  logic                      out_busy;
  logic                      emit_fire;
  logic signed [XY_W-1:0]    re_ext;
  logic signed [XY_W-1:0]    im_ext;
  logic signed [XY_W-1:0]    xs;
  logic signed [XY_W-1:0]    ys;
  logic signed [Z_W-1:0]     atan_step;
  logic signed [Z_W-1:0]     z_round;

  // Adjust the count by one step between two angles, saturating at the limit
  function automatic logic signed [COUNT_W-1:0] count_step(
    input logic signed [COUNT_W-1:0] cnt,
    input logic signed [ANGLE_W-1:0] from_a,
    input logic signed [ANGLE_W-1:0] to_a
  );
    logic signed [16:0]        d;
    logic signed [COUNT_W-1:0] r;
    d = {to_a[ANGLE_W-1], to_a} - {from_a[ANGLE_W-1], from_a};
    r = cnt;
    if (d < -ANGLE_THRESHOLD) begin
      if (cnt < COUNT_LIM) r = cnt + 14'sd1;
    end else if (d > ANGLE_THRESHOLD) begin
      if (cnt > -COUNT_LIM) r = cnt - 14'sd1;
    end
    return r;
  endfunction

  assign in_stall  = (ctrl.op != OP_LOAD);
  assign in_accept = in_valid && !in_stall;
  assign out_busy  = out_valid && out_stall;
  assign emit_fire = (ctrl.op == OP_EMIT) && !out_busy;

  assign flags.in_valid  = in_valid;
  assign flags.iter_more = (iter_cnt != ITER_W'(CORDIC_STEPS - 1));
  assign flags.last      = last_reg;
  assign flags.out_busy  = out_busy;

  bpwc_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctrl  (ctrl)
  );

  // Inputs scaled by 2^8 into the CORDIC width
  assign re_ext = {{(XY_W-24){sample_real[15]}}, sample_real, 8'b0};
  assign im_ext = {{(XY_W-24){sample_imag[15]}}, sample_imag, 8'b0};

  assign xs        = x >>> iter_cnt;
  assign ys        = y >>> iter_cnt;
  assign atan_step = {{(Z_W-ATAN_W){1'b0}}, atan_fine(ATAN_IW'(iter_cnt))};
  assign z_round   = z + 26'sd128;

  // CORDIC unit: load with quadrant fold, iterate, round to a binary angle
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_LOAD: begin
        if (in_accept) begin
          zero_in  <= (sample_real == 16'sd0) && (sample_imag == 16'sd0);
          last_reg <= last_point;
          iter_cnt <= '0;
          if (sample_real[15] && !sample_imag[15]) begin
            // left half, upper: rotate by -pi/2
            x <= im_ext;
            y <= -re_ext;
            z <= HALF_PI_FINE;
          end else if (sample_real[15]) begin
            // left half, lower: rotate by +pi/2
            x <= -im_ext;
            y <= re_ext;
            z <= -HALF_PI_FINE;
          end else begin
            x <= re_ext;
            y <= im_ext;
            z <= '0;
          end
        end
      end
      OP_ITER: begin
        iter_cnt <= iter_cnt + ITER_W'(1);
        if (y > 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + atan_step;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - atan_step;
        end
      end
      OP_ROUND: begin
        // round half up, wrap to 16 bits so +pi reads as -pi
        angle <= zero_in ? '0 : z_round[ANGLE_W+7:8];
      end
      default: begin
      end
    endcase
  end

  // Run state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      first_angle    <= '0;
      previous_angle <= '0;
      running_count  <= '0;
      run_started    <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_valid && !out_stall && !emit_fire) out_valid <= 1'b0;
      case (ctrl.op)
        OP_ADVANCE: begin
          if (!run_started) begin
            first_angle   <= angle;
            running_count <= '0;
            run_started   <= 1'b1;
          end else begin
            running_count <= count_step(running_count, previous_angle, angle);
          end
          previous_angle <= angle;
        end
        OP_CLOSE: begin
          // close the loop from the last angle back to the first
          running_count <= count_step(running_count, previous_angle, first_angle);
        end
        OP_EMIT: begin
          if (emit_fire) begin
            out_valid      <= 1'b1;
            first_angle    <= '0;
            previous_angle <= '0;
            running_count  <= '0;
            run_started    <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) winding_count <= running_count;
  end

  // Accepted sample must go straight into the iteration step
  `BPWC_ASSERT_NEXT(a_accept_to_iter, clk, rst, in_accept, ctrl.op == OP_ITER)
  // Emission drops the run state and raises the output
  `BPWC_ASSERT_NEXT(a_emit_clears, clk, rst, emit_fire,
                    out_valid && !run_started && running_count == 14'sd0)
  // Count never leaves the saturation window
  `BPWC_ASSERT_NOW(a_count_range, clk, rst, 1'b1,
                   running_count <= COUNT_LIM && running_count >= -COUNT_LIM)

endmodule

// ----- bench/winding_checker.sv -----
module winding_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic signed [15:0]                  sample_real,
  input  logic signed [15:0]                  sample_imag,
  input  logic                                last_point,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic signed [bpwc_pkg::COUNT_W-1:0] winding_count,
  output int                                  fail_count,
  output int                                  pending,
  output int                                  checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [bpwc_pkg::COUNT_W-1:0] count_t;

  localparam longint QUARTER_TURN = 64'sd4194304;
  localparam int     WRAP_LIMIT   = 49152;
  localparam int     TALLY_MAX    = bpwc_pkg::COUNT_LIMIT;

  // arctan(2^-i) in 2^-24 turn
  localparam longint ATAN_FINE [24] = '{
    2097152, 1238021, 654136, 332050, 166669, 83416, 41718, 20860,
    10430, 5215, 2608, 1304, 652, 326, 163, 81,
    41, 20, 10, 5, 3, 1, 1, 0
  };

  count_t expected_counts[$];
  int     first_ph;
  int     prev_ph;
  int     run_tally;
  logic   run_open;
  int     fails;
  int     checked;

  // Vectoring CORDIC on inputs scaled by 2^8, result in 16-bit binary angle.
  function automatic int sample_phase(logic signed [15:0] re, logic signed [15:0] im);
    longint x;
    longint y;
    longint z;
    longint t;
    longint xs;
    longint ys;
    logic signed [15:0] ph;
    if (re == 0 && im == 0) return 0;
    x = longint'(re) * 256;
    y = longint'(im) * 256;
    z = 0;
    // fold the left half plane onto the right one
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = QUARTER_TURN;
      end else begin
        t = x; x = -y; y = t; z = -QUARTER_TURN;
      end
    end
    for (int i = 0; i < bpwc_pkg::CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_FINE[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_FINE[i];
      end
    end
    z = (z + 128) >>> 8;
    ph = z[15:0];
    return int'(ph);
  endfunction

  // A jump past -1.5 pi is a forward wrap, past +1.5 pi a backward one.
  function automatic int wrapped_count(int cnt, int from_ph, int to_ph);
    int d;
    d = to_ph - from_ph;
    if (d < -WRAP_LIMIT) begin
      if (cnt < TALLY_MAX) cnt++;
    end else if (d > WRAP_LIMIT) begin
      if (cnt > -TALLY_MAX) cnt--;
    end
    return cnt;
  endfunction

  always @(posedge clk) begin : watch
    int     ph;
    count_t want;
    if (rst) begin
      expected_counts.delete();
      first_ph  = 0;
      prev_ph   = 0;
      run_tally = 0;
      run_open  = 1'b0;
      fails     = 0;
      checked   = 0;
    end else begin
      if (in_valid && !in_stall) begin
        ph = sample_phase(sample_real, sample_imag);
        if (!run_open) begin
          first_ph  = ph;
          prev_ph   = ph;
          run_tally = 0;
          run_open  = 1'b1;
        end else begin
          run_tally = wrapped_count(run_tally, prev_ph, ph);
          prev_ph   = ph;
        end
        if (last_point) begin
          // close the loop, then drop the run state
          run_tally = wrapped_count(run_tally, prev_ph, first_ph);
          expected_counts.push_back(count_t'(run_tally));
          first_ph  = 0;
          prev_ph   = 0;
          run_tally = 0;
          run_open  = 1'b0;
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_counts.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("error: unexpected winding count %0d", winding_count);
        end else begin
          want = expected_counts.pop_front();
          checked++;
          if (winding_count !== want) begin
            fails++;
            if (fails <= 10)
              $display("error: winding_count expected %0d got %0d", want, winding_count);
          end
        end
      end
    end
    fail_count    <= fails;
    pending       <= expected_counts.size();
    checked_count <= checked;
  end

endmodule

// ----- bench/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam real PI           = 3.14159265358979323846;
  localparam int  RUN_LIMIT    = 3000000;
  localparam int  SPIRAL_TURNS = 16;
  localparam int  HOLD_LEN     = 400;

  logic                                clk = 1'b0;
  logic                                rst = 1'b1;
  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic signed [15:0]                  sample_real = '0;
  logic signed [15:0]                  sample_imag = '0;
  logic                                last_point = 1'b0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic signed [bpwc_pkg::COUNT_W-1:0] winding_count;

  int   fail_count;
  int   pending;
  int   checked_count;
  int   samples_sent = 0;
  int   loops_sent   = 0;
  int   cycle_count  = 0;
  int   hold_left    = 0;
  logic hold_go   = 1'b0;
  logic hold_used = 1'b0;
  logic quiet     = 1'b0;

  always #5 clk = ~clk;

  boundary_phase_winding_counter_top DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_real  (sample_real),
    .sample_imag  (sample_imag),
    .last_point   (last_point),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .winding_count(winding_count)
  );

  winding_checker count_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample_real  (sample_real),
    .sample_imag  (sample_imag),
    .last_point   (last_point),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .winding_count(winding_count),
    .fail_count   (fail_count),
    .pending      (pending),
    .checked_count(checked_count)
  );

  // Guard against a hung handshake: end the run once the cycle budget is gone.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= RUN_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure, one long hold-off on request, and none
  // at all while the quiet window is open. The hold counts its own cycles so
  // the sender keeps pushing samples into a full block.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      hold_used <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_used) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_LEN - 1;
      hold_used <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 21);
    end
  end

  // Offer one sample and hold it until the block takes the transaction.
  // Random idle cycles go in front unless the quiet window is open.
  task automatic send_sample(logic signed [15:0] re, logic signed [15:0] im, logic last);
    if (!quiet) begin
      while ($urandom_range(99) < 21) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    sample_real <= re;
    sample_imag <= im;
    last_point  <= last;
    do @(posedge clk); while (in_stall);
    samples_sent++;
    if (last) loops_sent++;
  endtask

  function automatic logic signed [15:0] to_q15(real v);
    int r;
    r = (v >= 0.0) ? $rtoi(v + 0.5) : -$rtoi(-v + 0.5);
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return 16'(r);
  endfunction

  task automatic send_polar(real radius, real ang, logic last);
    send_sample(to_q15(radius * $cos(ang)), to_q15(radius * $sin(ang)), last);
  endtask

  function automatic logic signed [15:0] corner_value();
    logic signed [15:0] v;
    case ($urandom_range(4))
      0:       v = 16'sh8000;
      1:       v = -16'sd1;
      2:       v = 16'sd0;
      3:       v = 16'sd1;
      default: v = 16'sh7fff;
    endcase
    return v;
  endfunction

  // Closed loop of n points winding `turns` times, jittered, at one radius.
  task automatic send_ring(int n, int turns, real radius);
    real ph0;
    real jit;
    ph0 = 2.0 * PI * real'($urandom_range(999)) / 1000.0;
    for (int j = 0; j < n; j++) begin
      jit = 0.6 * (real'($urandom_range(1000)) / 1000.0 - 0.5);
      send_polar(radius, ph0 + 2.0 * PI * turns * j / n + jit, j == n - 1);
    end
  endtask

  // Three points per turn (0, 0.7 pi, -0.9 pi): the step across pi is small
  // enough to count, so every turn adds one. Negative mirrors the loop.
  task automatic send_spiral(int turns, bit negative);
    real sgn;
    sgn = negative ? -1.0 : 1.0;
    for (int t = 0; t < turns; t++) begin
      send_polar(30000.0, 0.0, 1'b0);
      send_polar(30000.0, sgn * 0.7 * PI, 1'b0);
      send_polar(30000.0, sgn * -0.9 * PI, t == turns - 1);
    end
  endtask

  initial begin : stimulus
    int base;
    int n;
    int kind;
    real radius;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: zero sample alone, a full-scale corner alone.
    send_sample(16'sd0, 16'sd0, 1'b1);
    send_sample(16'sh8000, 16'sh8000, 1'b1);
    // Four axis extremes: the step onto -pi lands exactly on the threshold.
    send_sample(16'sh7fff, 16'sd0, 1'b0);
    send_sample(16'sd0, 16'sh7fff, 1'b0);
    send_sample(16'sh8000, 16'sd0, 1'b0);
    send_sample(16'sd0, 16'sh8000, 1'b1);
    // One turn forward, one turn backward.
    send_spiral(1, 1'b0);
    send_spiral(1, 1'b1);
    // Zero sample inside a run, other corners around it.
    send_sample(16'sh7fff, 16'sh7fff, 1'b0);
    send_sample(16'sd0, 16'sd0, 1'b0);
    send_sample(16'sh8000, 16'sh7fff, 1'b0);
    send_sample(16'sh7fff, 16'sh8000, 1'b1);
    // Tiny magnitudes next to the origin.
    send_sample(-16'sd1, 16'sd0, 1'b0);
    send_sample(-16'sd1, -16'sd1, 1'b0);
    send_sample(16'sd1, -16'sd1, 1'b1);

    // Random: mostly well-formed rings, some noise, corners and one-point runs.
    base = samples_sent;
    while (samples_sent - base < 600) begin
      quiet <= (samples_sent - base >= 250) && (samples_sent - base < 400);
      if (!hold_go && samples_sent - base >= 450) begin
        // Back up the result side and keep offering one-point runs.
        hold_go <= 1'b1;
        for (int i = 0; i < 6; i++)
          send_sample(16'($urandom), 16'($urandom), 1'b1);
      end
      kind = $urandom_range(9);
      if (kind <= 5) begin
        radius = ($urandom_range(3) == 0) ? real'($urandom_range(1, 64))
                                          : real'($urandom_range(1, 32767));
        send_ring($urandom_range(1, 40), int'($urandom_range(6)) - 3, radius);
      end else if (kind <= 7) begin
        n = $urandom_range(1, 12);
        for (int j = 0; j < n; j++) begin
          if ($urandom_range(7) == 0)
            send_sample(16'sd0, 16'sd0, j == n - 1);
          else
            send_sample(16'($urandom), 16'($urandom), j == n - 1);
        end
      end else if (kind == 8) begin
        n = $urandom_range(1, 8);
        for (int j = 0; j < n; j++)
          send_sample(corner_value(), corner_value(), j == n - 1);
      end else begin
        send_sample(16'($urandom), 16'($urandom), 1'b1);
      end
    end
    quiet <= 1'b0;

    // Long runs: many turns in one loop, both ways.
    send_spiral(SPIRAL_TURNS, 1'b0);
    send_spiral(SPIRAL_TURNS, 1'b1);
    in_valid   <= 1'b0;
    last_point <= 1'b0;

    // Let the checker see the last transaction, drain, then settle.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (bpwc_pkg::CORDIC_STEPS + 12) @(posedge clk);

    $display("Sent %0d samples in %0d loops; %0d winding counts compared.",
             samples_sent, loops_sent, checked_count);
    $display("Covered corners, zero samples, random rings and %0d-turn spirals.",
             SPIRAL_TURNS);
    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
